### rtl/core/mwa_pkg.sv
// ----------------------------------------------------------------------------
// mwa_pkg
// Types, opcodes and width helpers shared by the multi-width integer ALU.
// ----------------------------------------------------------------------------
package mwa_pkg;

    localparam int IN_DEPTH  = 4;
    localparam int OUT_DEPTH = 4;

    localparam logic [4:0] OP_ADD   = 5'd0;
    localparam logic [4:0] OP_SUB   = 5'd1;
    localparam logic [4:0] OP_MUL   = 5'd2;
    localparam logic [4:0] OP_DIV   = 5'd3;
    localparam logic [4:0] OP_NEG   = 5'd4;
    localparam logic [4:0] OP_ABS   = 5'd5;
    localparam logic [4:0] OP_AND   = 5'd6;
    localparam logic [4:0] OP_OR    = 5'd7;
    localparam logic [4:0] OP_XOR   = 5'd8;
    localparam logic [4:0] OP_NOT   = 5'd9;
    localparam logic [4:0] OP_SHL   = 5'd10;
    localparam logic [4:0] OP_SHR   = 5'd11;
    localparam logic [4:0] OP_SHA   = 5'd12;
    localparam logic [4:0] OP_BSWAP = 5'd13;
    localparam logic [4:0] OP_CLZ   = 5'd14;
    localparam logic [4:0] OP_ZEXT  = 5'd15;
    localparam logic [4:0] OP_SEXT  = 5'd16;
    localparam logic [4:0] OP_TRUNC = 5'd17;

    localparam logic [1:0] W8  = 2'd0;
    localparam logic [1:0] W16 = 2'd1;
    localparam logic [1:0] W32 = 2'd2;
    localparam logic [1:0] W64 = 2'd3;

    localparam logic [6:0] DIV_STEPS = 7'd64;

    typedef struct packed {
        logic [4:0]  op;
        logic [1:0]  width;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
        logic [1:0]  target_width;
    } t_in;

    typedef struct packed {
        logic [63:0] result;
        logic [1:0]  result_width;
        logic        carry;
        logic        error;
    } t_out;

    // classified operation as it travels from the front to the back
    typedef struct packed {
        logic [4:0]  op;
        logic [1:0]  w;
        logic [1:0]  tw;
        logic [63:0] a;
        logic [63:0] b;
        logic [7:0]  cnt;
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        logic        q_neg;
        logic        div_zero;
    } t_uop;

    function automatic logic [63:0] width_mask(input logic [1:0] w);
        logic [63:0] m;
        unique case (w)
            W8:      m = 64'h0000_0000_0000_00FF;
            W16:     m = 64'h0000_0000_0000_FFFF;
            W32:     m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] width_bits(input logic [1:0] w);
        logic [7:0] n;
        unique case (w)
            W8:      n = 8'd8;
            W16:     n = 8'd16;
            W32:     n = 8'd32;
            default: n = 8'd64;
        endcase
        return n;
    endfunction

    function automatic logic sign_bit(input logic [63:0] v, input logic [1:0] w);
        logic s;
        unique case (w)
            W8:      s = v[7];
            W16:     s = v[15];
            W32:     s = v[31];
            default: s = v[63];
        endcase
        return s;
    endfunction

    function automatic logic [63:0] sx64(input logic [63:0] v, input logic [1:0] w);
        logic [63:0] m;
        m = width_mask(w);
        return sign_bit(v, w) ? ((v & m) | ~m) : (v & m);
    endfunction

endpackage

### rtl/core/mwa_front.sv
// ----------------------------------------------------------------------------
// mwa_front
// Masks operands to the operand width and precomputes divide signs and
// magnitudes so the back end sees a classified operation.
// ----------------------------------------------------------------------------
module mwa_front (
    input  mwa_pkg::t_in  i_in,
    output mwa_pkg::t_uop o_uop
);

    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] sa;
    logic [63:0] sb;

    always_comb begin
        m  = mwa_pkg::width_mask(i_in.width);
        a  = i_in.operand_a & m;
        b  = i_in.operand_b & m;
        sa = mwa_pkg::sx64(a, i_in.width);
        sb = mwa_pkg::sx64(b, i_in.width);

        o_uop.op       = i_in.op;
        o_uop.w        = i_in.width;
        o_uop.tw       = i_in.target_width;
        o_uop.a        = a;
        o_uop.b        = b;
        o_uop.cnt      = i_in.operand_b[7:0];
        o_uop.mag_a    = sa[63] ? (64'd0 - sa) : sa;
        o_uop.mag_b    = sb[63] ? (64'd0 - sb) : sb;
        o_uop.q_neg    = sa[63] ^ sb[63];
        o_uop.div_zero = (b == 64'd0);
    end

endmodule

### rtl/core/mwa_fifo.sv
// ----------------------------------------------------------------------------
// mwa_fifo
// Small register queue used between the front and back and at the output.
// ----------------------------------------------------------------------------
module mwa_fifo #(
    parameter int  DEPTH = mwa_pkg::IN_DEPTH,
    parameter type T     = mwa_pkg::t_uop
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  T                             i_data,
    input  logic                         i_pop,
    output T                             o_data,
    output logic                         o_full,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    T                r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            wr_en;
    logic            rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(wr_en) - CW'(rd_en);
        end
    end

endmodule

### rtl/core/mwa_exec.sv
// ----------------------------------------------------------------------------
// mwa_exec
// Back end: two-stage execute pipe with split 64-bit multiply and an
// iterative radix-2 divider that holds the first stage while it runs.
// ----------------------------------------------------------------------------
module mwa_exec #(
    parameter int OUT_DEPTH = mwa_pkg::OUT_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    input  mwa_pkg::t_uop                    i_q_uop,
    output logic                             o_q_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]   i_out_count,
    output logic                             o_out_push,
    output mwa_pkg::t_out                    o_out
);

    localparam int CW = $clog2(OUT_DEPTH+1);

    typedef struct packed {
        mwa_pkg::t_out res;
        logic          is_mul;
        logic [63:0]   mask;
        logic [63:0]   p_ll;
        logic [31:0]   p_lh;
        logic [31:0]   p_hl;
    } t_e2;

    logic          r_e1_valid;
    mwa_pkg::t_uop r_e1;
    logic          r_e2_valid;
    t_e2           r_e2;
    t_e2           n_e2;
    logic [6:0]    r_dv_cnt;
    logic [63:0]   r_dv_rem;
    logic [63:0]   r_dv_q;

    logic          en;
    logic          e1_div;
    logic          e1_adv;
    logic          e1_load;
    logic [64:0]   rem_sh;
    logic          rem_ge;

    // room for everything still in flight
    assign en      = (i_out_count <= CW'(OUT_DEPTH-2));
    assign e1_div  = (r_e1.op == mwa_pkg::OP_DIV);
    assign e1_adv  = en && r_e1_valid && (!e1_div || r_dv_cnt == 7'd0);
    assign e1_load = !i_q_empty && (!r_e1_valid || e1_adv);
    assign o_q_pop = e1_load;

    assign rem_sh  = {r_dv_rem, r_dv_q[63]};
    assign rem_ge  = (rem_sh >= {1'b0, r_e1.mag_b});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_valid <= 1'b0;
            r_e2_valid <= 1'b0;
            r_dv_cnt   <= '0;
        end else begin
            if (e1_load) begin
                r_e1_valid <= 1'b1;
            end else if (e1_adv) begin
                r_e1_valid <= 1'b0;
            end
            if (en) begin
                r_e2_valid <= e1_adv;
            end
            if (e1_load) begin
                r_dv_cnt <= (i_q_uop.op == mwa_pkg::OP_DIV) ? mwa_pkg::DIV_STEPS : 7'd0;
            end else if (r_dv_cnt != 7'd0) begin
                r_dv_cnt <= r_dv_cnt - 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (e1_load) begin
            r_e1     <= i_q_uop;
            r_dv_rem <= '0;
            r_dv_q   <= i_q_uop.mag_a;
        end else if (r_dv_cnt != 7'd0) begin
            r_dv_rem <= rem_ge ? 64'(rem_sh - {1'b0, r_e1.mag_b}) : rem_sh[63:0];
            r_dv_q   <= {r_dv_q[62:0], rem_ge};
        end
        if (e1_adv) begin
            r_e2 <= n_e2;
        end
    end

    // first stage: every op but the multiply finishes here
    logic [63:0] m;
    logic [63:0] tm;
    logic [7:0]  nbits;
    logic [64:0] sum;
    logic [63:0] s;
    logic [63:0] al;
    logic [6:0]  lz;
    logic [63:0] r;
    logic [1:0]  rw;
    logic        cy;
    logic        er;

    always_comb begin
        m     = mwa_pkg::width_mask(r_e1.w);
        tm    = mwa_pkg::width_mask(r_e1.tw);
        nbits = mwa_pkg::width_bits(r_e1.w);
        sum   = {1'b0, r_e1.a} + {1'b0, r_e1.b};
        s     = mwa_pkg::sx64(r_e1.a, r_e1.w);
        al    = r_e1.a << (8'd64 - nbits);
        lz    = 7'(nbits);
        for (int i = 0; i < 64; i++) begin
            if (al[i]) begin
                lz = 7'(63 - i);
            end
        end
        r  = '0;
        rw = r_e1.w;
        cy = 1'b0;
        er = 1'b0;
        unique case (r_e1.op)
            mwa_pkg::OP_ADD: begin
                r = sum[63:0] & m;
                unique case (r_e1.w)
                    mwa_pkg::W8:  cy = sum[8];
                    mwa_pkg::W16: cy = sum[16];
                    mwa_pkg::W32: cy = sum[32];
                    default:      cy = sum[64];
                endcase
            end
            mwa_pkg::OP_SUB: begin
                r  = (r_e1.a - r_e1.b) & m;
                cy = (r_e1.b > r_e1.a);
            end
            mwa_pkg::OP_MUL: r = '0;
            mwa_pkg::OP_DIV: begin
                er = r_e1.div_zero;
                if (!r_e1.div_zero) begin
                    r = (r_e1.q_neg ? (64'd0 - r_dv_q) : r_dv_q) & m;
                end
            end
            mwa_pkg::OP_NEG: r = (64'd0 - r_e1.a) & m;
            mwa_pkg::OP_ABS: r = r_e1.mag_a & m;
            mwa_pkg::OP_AND: r = r_e1.a & r_e1.b;
            mwa_pkg::OP_OR:  r = r_e1.a | r_e1.b;
            mwa_pkg::OP_XOR: r = r_e1.a ^ r_e1.b;
            mwa_pkg::OP_NOT: r = ~r_e1.a & m;
            mwa_pkg::OP_SHL: r = (r_e1.cnt < nbits) ? ((r_e1.a << r_e1.cnt) & m) : '0;
            mwa_pkg::OP_SHR: r = (r_e1.cnt < nbits) ? (r_e1.a >> r_e1.cnt) : '0;
            mwa_pkg::OP_SHA: begin
                if (r_e1.cnt < nbits) begin
                    r = 64'($signed(s) >>> r_e1.cnt) & m;
                end else begin
                    r = {64{s[63]}} & m;
                end
            end
            mwa_pkg::OP_BSWAP: begin
                unique case (r_e1.w)
                    mwa_pkg::W8:  r = r_e1.a;
                    mwa_pkg::W16: r = {48'd0, r_e1.a[7:0], r_e1.a[15:8]};
                    mwa_pkg::W32: r = {32'd0, {<<8{r_e1.a[31:0]}}};
                    default:      r = {<<8{r_e1.a}};
                endcase
            end
            mwa_pkg::OP_CLZ: begin
                r  = {57'd0, lz};
                rw = mwa_pkg::W8;
            end
            mwa_pkg::OP_ZEXT: begin
                r = r_e1.a;
                if (r_e1.tw > r_e1.w) begin
                    rw = r_e1.tw;
                end else begin
                    er = 1'b1;
                end
            end
            mwa_pkg::OP_SEXT: begin
                if (r_e1.tw > r_e1.w) begin
                    r  = s & tm;
                    rw = r_e1.tw;
                end else begin
                    r  = r_e1.a;
                    er = 1'b1;
                end
            end
            mwa_pkg::OP_TRUNC: begin
                if (r_e1.tw < r_e1.w) begin
                    r  = r_e1.a & tm;
                    rw = r_e1.tw;
                end else begin
                    r  = r_e1.a;
                    er = 1'b1;
                end
            end
            default: er = 1'b1;
        endcase

        n_e2.res.result       = r;
        n_e2.res.result_width = rw;
        n_e2.res.carry        = cy;
        n_e2.res.error        = er;
        n_e2.is_mul           = (r_e1.op == mwa_pkg::OP_MUL);
        n_e2.mask             = m;
        n_e2.p_ll             = r_e1.a[31:0] * r_e1.b[31:0];
        n_e2.p_lh             = 32'(r_e1.a[31:0] * r_e1.b[63:32]);
        n_e2.p_hl             = 32'(r_e1.a[63:32] * r_e1.b[31:0]);
    end

    // second stage: fold the multiply partial products
    logic [63:0] mul;

    always_comb begin
        mul   = r_e2.p_ll + {32'(r_e2.p_lh + r_e2.p_hl), 32'd0};
        o_out = r_e2.res;
        if (r_e2.is_mul) begin
            o_out.result = mul & r_e2.mask;
        end
    end

    assign o_out_push = en && r_e2_valid;

    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> (i_out_count < CW'(OUT_DEPTH)))
        else $error("result written into a full output queue");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (e1_load && i_q_uop.op == mwa_pkg::OP_DIV) |=> (r_dv_cnt == mwa_pkg::DIV_STEPS))
        else $error("divider did not start on a divide");

    a_nondiv_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_e1_valid && !e1_div) |-> e1_adv)
        else $error("non-divide op stalled in first stage");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e1_valid && e1_div && r_dv_cnt != 7'd0) |=> (r_e1_valid && $stable(r_e1.op)))
        else $error("divide left first stage before finishing");

endmodule

### rtl/core/multi_width_integer_alu.sv
// ----------------------------------------------------------------------------
// multi_width_integer_alu
// Integer ALU on 8/16/32/64-bit operands with queue interfaces on both sides.
// ----------------------------------------------------------------------------
// path: input queue, first execute stage, second execute stage, output queue, each registered
// divide: iterates in the radix-2 divider, which holds the first execute stage while it runs
// throughput: one request per cycle while the output queue has room; a divide holds the next until done
// results leave in request order; queue depth 4 on each side
// reset: synchronous active low, empties both queues and the execute pipe
module multi_width_integer_alu #(
    parameter int IN_DEPTH  = mwa_pkg::IN_DEPTH,
    parameter int OUT_DEPTH = mwa_pkg::OUT_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  mwa_pkg::t_in  i_in,
    output logic          empty,
    input  logic          pop,
    output mwa_pkg::t_out o_out
);

    mwa_pkg::t_uop                     fr_uop;
    mwa_pkg::t_uop                     q_uop;
    logic                              q_empty;
    logic                              q_pop;
    logic [$clog2(IN_DEPTH+1)-1:0]     q_count;
    logic [$clog2(OUT_DEPTH+1)-1:0]    out_count;
    logic                              out_push;
    logic                              out_full;
    mwa_pkg::t_out                     ex_out;

    mwa_front u_front (
        .i_in  (i_in),
        .o_uop (fr_uop)
    );

    mwa_fifo #(
        .DEPTH (IN_DEPTH),
        .T     (mwa_pkg::t_uop)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (fr_uop),
        .i_pop   (q_pop),
        .o_data  (q_uop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    mwa_exec #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_uop     (q_uop),
        .o_q_pop     (q_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out       (ex_out)
    );

    mwa_fifo #(
        .DEPTH (OUT_DEPTH),
        .T     (mwa_pkg::t_out)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (ex_out),
        .i_pop   (pop),
        .o_data  (o_out),
        .o_full  (out_full),
        .o_empty (empty),
        .o_count (out_count)
    );

    a_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (q_count == $bits(q_count)'(IN_DEPTH)))
        else $error("input queue full flag out of step with count");

    a_out_never_full_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("execute pipe pushed into a full output queue");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("execute pipe popped an empty input queue");

endmodule
